// ===== hdl/rsh_pkg.sv =====
// ----------------------------------------------------------------------------
// rsh_pkg
// Shared constants and types for the ray / sphere hit test pipeline.
// ----------------------------------------------------------------------------
package rsh_pkg;

    // Default coordinate width (signed Q8.8 at 16 bits)
    localparam int DEF_COORD_WIDTH = 16;

    // Pipeline stage numbering
    localparam int STG_REL    = 0;  // relative origin, operand capture
    localparam int STG_PROD   = 1;  // component products
    localparam int STG_SUM    = 2;  // a, h, c sums and early decision
    localparam int STG_PART   = 3;  // partial products of h*h and a*c
    localparam int STG_CMB    = 4;  // recombined h*h and a*c
    localparam int STG_OUT    = 5;  // final compare, output register
    localparam int NUM_STAGES = 6;

    // Per-stage load enables from the pipeline control
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } rsh_ctrl_t;

endpackage

// ===== hdl/rsh_ray_if.sv =====
// ----------------------------------------------------------------------------
// rsh_ray_if
// Ray and sphere input channel: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface rsh_ray_if #(
    parameter int COORD_WIDTH = rsh_pkg::DEF_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [COORD_WIDTH-1:0] dir_x;
    logic signed [COORD_WIDTH-1:0] dir_y;
    logic signed [COORD_WIDTH-1:0] dir_z;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
    logic        [COORD_WIDTH-2:0] sphere_radius;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               center_x, center_y, center_z, sphere_radius,
        input  ready
    );

    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               center_x, center_y, center_z, sphere_radius,
        output ready
    );
endinterface

// ===== hdl/rsh_hit_if.sv =====
// ----------------------------------------------------------------------------
// rsh_hit_if
// Hit result channel: valid/ready handshake with a one-bit hit flag.
// ----------------------------------------------------------------------------
interface rsh_hit_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (
        output valid, hit,
        input  ready
    );

    modport sink (
        input  valid, hit,
        output ready
    );
endinterface

// ===== hdl/rsh_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsh_ctrl
// Valid bit pipeline and per-stage load enables; bubbles collapse on stall.
// ----------------------------------------------------------------------------
module rsh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output rsh_pkg::rsh_ctrl_t ctrl
);
    import rsh_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] en;

    // A stage loads when empty or when its contents move on
    always_comb
    begin
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    // Advance valid bits with the data
    always_comb
    begin
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.en   = en;
    assign in_ready  = en[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    // Input backpressure only when every stage holds an item and output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> ((valid_reg == '1) && !out_ready))
        else $error("input stalled while pipeline has room");

    // Items in flight change only by transfers at the two ends
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(valid_reg) == $countones($past(valid_reg))
                  + ($past(in_valid && in_ready) ? 1 : 0)
                  - ($past(out_valid && out_ready) ? 1 : 0)))
        else $error("item lost or duplicated in pipeline");

    // A stall at the front implies a stall at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !en[0] |-> !en[NUM_STAGES-1])
        else $error("front stalled while output moves");

endmodule

// ===== hdl/rsh_geom.sv =====
// ----------------------------------------------------------------------------
// rsh_geom
// Front stages: relative origin, component products, and the sums
// a = D.D, h = L.D, c = L.L - r*r with the early hit decision.
// ----------------------------------------------------------------------------
module rsh_geom #(
    parameter int COORD_WIDTH = rsh_pkg::DEF_COORD_WIDTH
) (
    input  logic                            clk,
    input  rsh_pkg::rsh_ctrl_t              ctrl,
    input  logic signed [COORD_WIDTH-1:0]   origin_x,
    input  logic signed [COORD_WIDTH-1:0]   origin_y,
    input  logic signed [COORD_WIDTH-1:0]   origin_z,
    input  logic signed [COORD_WIDTH-1:0]   dir_x,
    input  logic signed [COORD_WIDTH-1:0]   dir_y,
    input  logic signed [COORD_WIDTH-1:0]   dir_z,
    input  logic signed [COORD_WIDTH-1:0]   center_x,
    input  logic signed [COORD_WIDTH-1:0]   center_y,
    input  logic signed [COORD_WIDTH-1:0]   center_z,
    input  logic        [COORD_WIDTH-2:0]   sphere_radius,
    output logic        [2*COORD_WIDTH+1:0] a_mag,
    output logic        [2*COORD_WIDTH+1:0] h_mag,
    output logic        [2*COORD_WIDTH+1:0] c_mag,
    output logic                            early_hit,
    output logic                            need_cmp
);
    import rsh_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int RW = W + 1;          // relative origin
    localparam int MW = 2 * W + 2;      // a, h sums and magnitudes
    localparam int CW = 2 * W + 3;      // c sum

    logic signed [W-1:0]    org [3];
    logic signed [W-1:0]    dvec [3];
    logic signed [W-1:0]    cen [3];

    logic signed [RW-1:0]   rel_reg [3];
    logic signed [W-1:0]    dir_reg [3];
    logic        [W-2:0]    rad_reg;

    logic signed [2*W-1:0]  dd_reg [3];
    logic signed [2*W:0]    rd_reg [3];
    logic signed [2*W+1:0]  rr_reg [3];
    logic        [2*W-3:0]  rad2_reg;

    logic signed [MW-1:0]   a_sum;
    logic signed [MW-1:0]   h_sum;
    logic signed [CW-1:0]   c_sum;
    logic                   a_nz;
    logic                   h_neg;
    logic                   c_neg;

    logic [MW-1:0]          a_reg;
    logic [MW-1:0]          hmag_reg;
    logic [MW-1:0]          c_reg;
    logic                   early_hit_reg;
    logic                   need_cmp_reg;

    // Gather coordinates into lanes
    always_comb
    begin
        org[0]  = origin_x;
        org[1]  = origin_y;
        org[2]  = origin_z;
        dvec[0] = dir_x;
        dvec[1] = dir_y;
        dvec[2] = dir_z;
        cen[0]  = center_x;
        cen[1]  = center_y;
        cen[2]  = center_z;
    end

    // Stage 0: relative origin L = O - C
    always_ff @(posedge clk)
    begin
        if (ctrl.en[STG_REL])
        begin
            for (int k = 0; k < 3; k++)
            begin
                rel_reg[k] <= $signed({org[k][W-1], org[k]})
                            - $signed({cen[k][W-1], cen[k]});
                dir_reg[k] <= dvec[k];
            end
            rad_reg <= sphere_radius;
        end
    end

    // Stage 1: component products
    always_ff @(posedge clk)
    begin
        if (ctrl.en[STG_PROD])
        begin
            for (int k = 0; k < 3; k++)
            begin
                dd_reg[k] <= (2*W)'(dir_reg[k]) * (2*W)'(dir_reg[k]);
                rd_reg[k] <= (2*W+1)'(rel_reg[k]) * (2*W+1)'(dir_reg[k]);
                rr_reg[k] <= (2*W+2)'(rel_reg[k]) * (2*W+2)'(rel_reg[k]);
            end
            rad2_reg <= (2*W-2)'(rad_reg) * (2*W-2)'(rad_reg);
        end
    end

    // Sum the components
    always_comb
    begin
        a_sum = MW'(dd_reg[0]) + MW'(dd_reg[1]) + MW'(dd_reg[2]);
        h_sum = MW'(rd_reg[0]) + MW'(rd_reg[1]) + MW'(rd_reg[2]);
        c_sum = CW'(rr_reg[0]) + CW'(rr_reg[1]) + CW'(rr_reg[2])
              - $signed(CW'(rad2_reg));
        a_nz  = (a_sum != '0);
        h_neg = h_sum[MW-1];
        c_neg = c_sum[CW-1];
    end

    // Stage 2: magnitudes and early decision
    always_ff @(posedge clk)
    begin
        if (ctrl.en[STG_SUM])
        begin
            a_reg         <= a_sum;
            hmag_reg      <= h_neg ? MW'(-h_sum) : h_sum;
            c_reg         <= c_sum[MW-1:0];
            early_hit_reg <= a_nz && c_neg;
            need_cmp_reg  <= a_nz && !c_neg && h_neg;
        end
    end

    assign a_mag     = a_reg;
    assign h_mag     = hmag_reg;
    assign c_mag     = c_reg;
    assign early_hit = early_hit_reg;
    assign need_cmp  = need_cmp_reg;

endmodule

// ===== hdl/rsh_disc.sv =====
// ----------------------------------------------------------------------------
// rsh_disc
// Back stages: discriminant test h*h >= a*c through split half-width
// partial products, then the hit flag register.
// ----------------------------------------------------------------------------
module rsh_disc #(
    parameter int COORD_WIDTH = rsh_pkg::DEF_COORD_WIDTH
) (
    input  logic                            clk,
    input  rsh_pkg::rsh_ctrl_t              ctrl,
    input  logic        [2*COORD_WIDTH+1:0] a_mag,
    input  logic        [2*COORD_WIDTH+1:0] h_mag,
    input  logic        [2*COORD_WIDTH+1:0] c_mag,
    input  logic                            early_hit,
    input  logic                            need_cmp,
    output logic                            hit
);
    import rsh_pkg::*;

    localparam int HALF = COORD_WIDTH + 1;
    localparam int MW   = 2 * HALF;
    localparam int PW   = 2 * MW;

    logic [HALF-1:0] h_lo, h_hi, a_lo, a_hi, c_lo, c_hi;

    logic [MW-1:0]   hh_ll_reg, hh_lh_reg, hh_hh_reg;
    logic [MW-1:0]   ac_ll_reg, ac_lh_reg, ac_hl_reg, ac_hh_reg;
    logic            early3_reg, need3_reg;

    logic [PW-1:0]   hh_reg, ac_reg;
    logic            early4_reg, need4_reg;

    logic            hit_reg;

    // Split operands into halves
    always_comb
    begin
        h_lo = h_mag[HALF-1:0];
        h_hi = h_mag[MW-1:HALF];
        a_lo = a_mag[HALF-1:0];
        a_hi = a_mag[MW-1:HALF];
        c_lo = c_mag[HALF-1:0];
        c_hi = c_mag[MW-1:HALF];
    end

    // Stage 3: half-width partial products
    always_ff @(posedge clk)
    begin
        if (ctrl.en[STG_PART])
        begin
            hh_ll_reg  <= MW'(h_lo) * MW'(h_lo);
            hh_lh_reg  <= MW'(h_lo) * MW'(h_hi);
            hh_hh_reg  <= MW'(h_hi) * MW'(h_hi);
            ac_ll_reg  <= MW'(a_lo) * MW'(c_lo);
            ac_lh_reg  <= MW'(a_lo) * MW'(c_hi);
            ac_hl_reg  <= MW'(a_hi) * MW'(c_lo);
            ac_hh_reg  <= MW'(a_hi) * MW'(c_hi);
            early3_reg <= early_hit;
            need3_reg  <= need_cmp;
        end
    end

    // Stage 4: recombine partial products
    always_ff @(posedge clk)
    begin
        if (ctrl.en[STG_CMB])
        begin
            hh_reg     <= {hh_hh_reg, hh_ll_reg} + (PW'(hh_lh_reg) << (HALF + 1));
            ac_reg     <= {ac_hh_reg, ac_ll_reg}
                        + ((PW'(ac_lh_reg) + PW'(ac_hl_reg)) << HALF);
            early4_reg <= early3_reg;
            need4_reg  <= need3_reg;
        end
    end

    // Stage 5: discriminant compare into the output register
    always_ff @(posedge clk)
    begin
        if (ctrl.en[STG_OUT])
        begin
            hit_reg <= early4_reg || (need4_reg && (hh_reg >= ac_reg));
        end
    end

    assign hit = hit_reg;

endmodule

// ===== hdl/ray_sphere_hit_test_unit.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_hit_test_unit
// Streaming ray / sphere hit test on signed fixed-point coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   ray    : sink channel; each transfer carries one ray (origin, direction)
//            and one sphere (center, radius) in signed fixed point.
//   result : source channel; one transfer per input item carrying hit, in
//            input order.
//   One item is accepted per cycle when the result side keeps up. The six
//   register stages are set by the component multipliers, the half-width
//   partial products of h*h and a*c, and the final wide compare.
//   Reset clears only the stage valid bits; the pipeline comes up empty and
//   ready. When the receiver stalls, the full output stage holds its result
//   and earlier stages keep filling bubbles; ray.ready drops only once all
//   six stages hold items.
// ----------------------------------------------------------------------------
module ray_sphere_hit_test_unit #(
    parameter int COORD_WIDTH = rsh_pkg::DEF_COORD_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    rsh_ray_if.sink   ray,
    rsh_hit_if.source result
);
    import rsh_pkg::*;

    localparam int MW = 2 * COORD_WIDTH + 2;

    rsh_ctrl_t       ctrl;
    logic [MW-1:0]   a_mag;
    logic [MW-1:0]   h_mag;
    logic [MW-1:0]   c_mag;
    logic            early_hit;
    logic            need_cmp;

    // Handshake and stage enables
    rsh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ray.valid),
        .in_ready  (ray.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .ctrl      (ctrl)
    );

    // Geometry front end
    rsh_geom #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_geom (
        .clk           (clk),
        .ctrl          (ctrl),
        .origin_x      (ray.origin_x),
        .origin_y      (ray.origin_y),
        .origin_z      (ray.origin_z),
        .dir_x         (ray.dir_x),
        .dir_y         (ray.dir_y),
        .dir_z         (ray.dir_z),
        .center_x      (ray.center_x),
        .center_y      (ray.center_y),
        .center_z      (ray.center_z),
        .sphere_radius (ray.sphere_radius),
        .a_mag         (a_mag),
        .h_mag         (h_mag),
        .c_mag         (c_mag),
        .early_hit     (early_hit),
        .need_cmp      (need_cmp)
    );

    // Discriminant back end
    rsh_disc #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_disc (
        .clk       (clk),
        .ctrl      (ctrl),
        .a_mag     (a_mag),
        .h_mag     (h_mag),
        .c_mag     (c_mag),
        .early_hit (early_hit),
        .need_cmp  (need_cmp),
        .hit       (result.hit)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming ray / sphere hit test unit. A queue
// of rays feeds a clocked driver; a clocked monitor compares every hit flag
// with an exact wide-integer prediction, in order. Phases vary the idling on
// both channels, including a long output hold that backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CW         = rsh_pkg::DEF_COORD_WIDTH;
    localparam int LONG_HOLD  = 300;
    localparam int DRAIN_WAIT = rsh_pkg::NUM_STAGES * 4;
    localparam int MAX_SHOWN  = 10;

    typedef struct {
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic signed [CW-1:0] origin_z;
        logic signed [CW-1:0] dir_x;
        logic signed [CW-1:0] dir_y;
        logic signed [CW-1:0] dir_z;
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic signed [CW-1:0] center_z;
        logic        [CW-2:0] sphere_radius;
    } ray_item_t;

    typedef struct {
        ray_item_t ray;
        logic      hit;
    } hit_expect_t;

    logic clk;
    logic rst_n;

    rsh_ray_if #(.COORD_WIDTH(CW)) ray_ch ();
    rsh_hit_if                     hit_ch ();

    ray_sphere_hit_test_unit #(
        .COORD_WIDTH (CW)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .ray    (ray_ch),
        .result (hit_ch)
    );

    ray_item_t   pending_rays[$];
    hit_expect_t expected_hits[$];
    ray_item_t   ray_on_bus;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_left;
    logic        hold_arm;
    int unsigned mismatch_count = 0;

    // Exact hit decision on the raw fixed-point codes
    function automatic logic ray_hits_sphere(ray_item_t it);
        logic signed [127:0] lx, ly, lz, dx, dy, dz, rad, a, h, c;
        lx  = $signed(it.origin_x) - $signed(it.center_x);
        ly  = $signed(it.origin_y) - $signed(it.center_y);
        lz  = $signed(it.origin_z) - $signed(it.center_z);
        dx  = $signed(it.dir_x);
        dy  = $signed(it.dir_y);
        dz  = $signed(it.dir_z);
        rad = $signed({1'b0, it.sphere_radius});
        a   = dx * dx + dy * dy + dz * dz;
        h   = lx * dx + ly * dy + lz * dz;
        c   = lx * lx + ly * ly + lz * lz - rad * rad;
        if (a == 0)
            return 1'b0;
        if (c < 0)
            return 1'b1;
        return (h < 0) && (h * h >= a * c);
    endfunction

    function automatic ray_item_t make_ray(int ox, int oy, int oz, int dx, int dy,
                                           int dz, int cx, int cy, int cz, int r);
        ray_item_t it;
        it.origin_x      = CW'(ox);
        it.origin_y      = CW'(oy);
        it.origin_z      = CW'(oz);
        it.dir_x         = CW'(dx);
        it.dir_y         = CW'(dy);
        it.dir_z         = CW'(dz);
        it.center_x      = CW'(cx);
        it.center_y      = CW'(cy);
        it.center_z      = CW'(cz);
        it.sphere_radius = (CW-1)'(r);
        return it;
    endfunction

    // Append a ray to the pending queue
    task automatic queue_ray(ray_item_t it);
        pending_rays.insert(pending_rays.size(), it);
    endtask

    // Signed value in [-lim, lim]
    function automatic int spread(int lim);
        return int'($urandom_range(2 * lim)) - lim;
    endfunction

    function automatic int corner_value();
        case ($urandom_range(4))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return -1;
            default: return int'($urandom);
        endcase
    endfunction

    // Random ray, shaped toward hits, near misses, surfaces and tangents
    function automatic ray_item_t random_ray();
        ray_item_t it;
        int        ox, oy, oz, dx, dy, dz, cx, cy, cz, r, k, sgn;
        ox = int'($urandom);
        oy = int'($urandom);
        oz = int'($urandom);
        dx = int'($urandom);
        dy = int'($urandom);
        dz = int'($urandom);
        cx = int'($urandom);
        cy = int'($urandom);
        cz = int'($urandom);
        r  = int'($urandom);
        k  = int'($urandom_range(1, 20));
        case ($urandom_range(9))
            // aim the sphere along the ray, or behind it
            2, 3, 4:
            begin
                ox = spread(4000);
                oy = spread(4000);
                oz = spread(4000);
                dx = spread(600);
                dy = spread(600);
                dz = spread(600);
                if ($urandom_range(3) == 0)
                    k = -k;
                cx = ox + k * dx + spread(300);
                cy = oy + k * dy + spread(300);
                cz = oz + k * dz + spread(300);
                r  = int'($urandom_range(1500));
            end
            // center near the origin, so the origin is mostly inside the sphere
            5:
            begin
                cx = ox + spread(500);
                cy = oy + spread(500);
                cz = oz + spread(500);
                r  = int'($urandom_range(600, 32767));
            end
            // origin on the surface along one axis
            6:
            begin
                r   = int'($urandom_range(1, 2000));
                cx  = spread(8000);
                cy  = spread(8000);
                cz  = spread(8000);
                sgn = $urandom_range(1) ? 1 : -1;
                ox  = cx;
                oy  = cy;
                oz  = cz;
                case ($urandom_range(2))
                    0:       ox = cx + sgn * r;
                    1:       oy = cy + sgn * r;
                    default: oz = cz + sgn * r;
                endcase
                dx = spread(400);
                dy = spread(400);
                dz = spread(400);
            end
            // tangent ray grazing the sphere along x, offset by r, plus or minus one, in y
            7:
            begin
                r  = int'($urandom_range(0, 3000));
                cx = spread(8000);
                cy = spread(8000);
                cz = spread(8000);
                ox = cx + spread(8000);
                oy = cy + r + spread(1);
                oz = cz;
                dx = spread(500);
                dy = 0;
                dz = 0;
            end
            8:
            begin
                ox = spread(64);
                oy = spread(64);
                oz = spread(64);
                dx = spread(64);
                dy = spread(64);
                dz = spread(64);
                cx = spread(64);
                cy = spread(64);
                cz = spread(64);
                r  = int'($urandom_range(64));
            end
            9:
            begin
                ox = corner_value();
                oy = corner_value();
                oz = corner_value();
                cx = corner_value();
                cy = corner_value();
                cz = corner_value();
                r  = $urandom_range(1) ? 32767 : corner_value();
                if ($urandom_range(1))
                begin
                    dx = 0;
                    dy = 0;
                    dz = 0;
                end
                else
                begin
                    dx = corner_value();
                    dy = corner_value();
                    dz = corner_value();
                end
            end
            default:
            begin
                // keep the fully random fields
            end
        endcase
        it = make_ray(ox, oy, oz, dx, dy, dz, cx, cy, cz, r);
        return it;
    endfunction

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Ray driver: hold on stall, record each transfer, offer the next ray
    always @(posedge clk or negedge rst_n)
    begin
        hit_expect_t exp_new;
        if (!rst_n)
        begin
            ray_ch.valid         <= 1'b0;
            ray_ch.origin_x      <= '0;
            ray_ch.origin_y      <= '0;
            ray_ch.origin_z      <= '0;
            ray_ch.dir_x         <= '0;
            ray_ch.dir_y         <= '0;
            ray_ch.dir_z         <= '0;
            ray_ch.center_x      <= '0;
            ray_ch.center_y      <= '0;
            ray_ch.center_z      <= '0;
            ray_ch.sphere_radius <= '0;
        end
        else if (!ray_ch.valid || ray_ch.ready)
        begin
            if (ray_ch.valid)
            begin
                exp_new.ray = ray_on_bus;
                exp_new.hit = ray_hits_sphere(ray_on_bus);
                expected_hits.insert(expected_hits.size(), exp_new);
            end
            if (pending_rays.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                ray_on_bus              = pending_rays.pop_front();
                ray_ch.valid           <= 1'b1;
                ray_ch.origin_x        <= ray_on_bus.origin_x;
                ray_ch.origin_y        <= ray_on_bus.origin_y;
                ray_ch.origin_z        <= ray_on_bus.origin_z;
                ray_ch.dir_x           <= ray_on_bus.dir_x;
                ray_ch.dir_y           <= ray_on_bus.dir_y;
                ray_ch.dir_z           <= ray_on_bus.dir_z;
                ray_ch.center_x        <= ray_on_bus.center_x;
                ray_ch.center_y        <= ray_on_bus.center_y;
                ray_ch.center_z        <= ray_on_bus.center_z;
                ray_ch.sphere_radius   <= ray_on_bus.sphere_radius;
            end
            else
            begin
                ray_ch.valid <= 1'b0;
            end
        end
    end

    // Long output hold, counted down once armed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_arm)
            hold_left <= LONG_HOLD;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Hit monitor: stall at random, compare each transfer with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        hit_expect_t exp_item;
        if (!rst_n)
        begin
            hit_ch.ready <= 1'b0;
        end
        else
        begin
            if (hit_ch.valid && hit_ch.ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display("unexpected result transfer: hit %0b", hit_ch.hit);
                end
                else
                begin
                    exp_item = expected_hits.pop_front();
                    if (hit_ch.hit !== exp_item.hit)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_SHOWN)
                            $display({"hit mismatch: expected %0b actual %0b  ",
                                      "O=(%0d,%0d,%0d) D=(%0d,%0d,%0d) ",
                                      "C=(%0d,%0d,%0d) r=%0d"},
                                     exp_item.hit, hit_ch.hit,
                                     exp_item.ray.origin_x, exp_item.ray.origin_y,
                                     exp_item.ray.origin_z, exp_item.ray.dir_x,
                                     exp_item.ray.dir_y, exp_item.ray.dir_z,
                                     exp_item.ray.center_x, exp_item.ray.center_y,
                                     exp_item.ray.center_z, exp_item.ray.sphere_radius);
                    end
                end
            end
            hit_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Wait until every queued ray has been transferred and answered
    task automatic wait_drained();
        while (pending_rays.size() != 0 || ray_ch.valid || expected_hits.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_random_phase(int n_rays, int unsigned send_pct,
                                    int unsigned stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        repeat (n_rays)
            queue_ray(random_ray());
        wait_drained();
    endtask

    // Stimulus and end of run
    initial
    begin
        hold_arm             = 1'b0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        rst_n                = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed rays: field extremes and the named corner cases
        queue_ray(make_ray(-32768, -32768, -32768, -32768, -32768, -32768,
                           -32768, -32768, -32768, 0));
        queue_ray(make_ray(32767, 32767, 32767, 32767, 32767, 32767,
                           32767, 32767, 32767, 32767));
        queue_ray(make_ray(-32768, -32768, -32768, 32767, 32767, 32767,
                           32767, 32767, 32767, 32767));
        queue_ray(make_ray(32767, 32767, 32767, -32768, -32768, -32768,
                           -32768, -32768, -32768, 32767));
        queue_ray(make_ray(32767, -32768, 32767, 1, -1, 1,
                           -32768, 32767, -32768, 0));
        // zero direction, even with the origin inside
        queue_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 256));
        queue_ray(make_ray(100, -50, 30, 0, 0, 0, 0, 0, 0, 32767));
        // origin inside
        queue_ray(make_ray(10, 20, 30, 256, 0, 0, 0, 0, 0, 1024));
        queue_ray(make_ray(10, 20, 30, -1, 0, 0, 0, 0, 0, 1024));
        // origin on the surface: inward, outward, grazing
        queue_ray(make_ray(256, 0, 0, -256, 0, 0, 0, 0, 0, 256));
        queue_ray(make_ray(256, 0, 0, 256, 0, 0, 0, 0, 0, 256));
        queue_ray(make_ray(256, 0, 0, 0, 256, 0, 0, 0, 0, 256));
        // tangent ray ahead and behind
        queue_ray(make_ray(-1024, 256, 0, 256, 0, 0, 0, 0, 0, 256));
        queue_ray(make_ray(-1024, 256, 0, -256, 0, 0, 0, 0, 0, 256));
        // clean hit, sphere behind, near miss
        queue_ray(make_ray(-1024, 100, 0, 256, 0, 0, 0, 0, 0, 256));
        queue_ray(make_ray(1024, 100, 0, 256, 0, 0, 0, 0, 0, 256));
        queue_ray(make_ray(-1024, 257, 0, 256, 0, 0, 0, 0, 0, 256));
        // point sphere on the ray path and just off it
        queue_ray(make_ray(-10, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        queue_ray(make_ray(-10, 1, 0, 1, 0, 0, 0, 0, 0, 0));
        wait_drained();

        // Random phases with varied idling
        run_random_phase(150, 0, 0);
        run_random_phase(150, 53, 0);
        run_random_phase(150, 0, 53);
        run_random_phase(150, 14, 14);

        // Back up the pipeline: hold the output while rays keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_arm       = 1'b1;
        @(negedge clk);
        hold_arm = 1'b0;
        repeat (50)
            queue_ray(random_ray());
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
        if (mismatch_count == 0 && expected_hits.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
